// File: src/psh_pkg.sv
`timescale 1ns / 1ps

package psh_pkg;

	localparam int HASH_W = 32;
	localparam int CHAR_W = 8;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [CHAR_W-1:0] char_t;

	// polynomial base
	localparam hash_t HASH_MULT = hash_t'(101);

	// queue status seen by the back end
	typedef struct packed {
		logic  avail;
		hash_t hash;
	} q_head_t;

endpackage

// File: src/psh_front.sv
`timescale 1ns / 1ps

module psh_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  psh_pkg::char_t s_tdata,
	input  logic           s_tlast,
	input  logic           s_tuser,
	input  logic           q_full,
	output logic           push,
	output psh_pkg::hash_t push_hash
);
	import psh_pkg::*;

	hash_t hash_q;
	hash_t next_hash;
	logic  accept;

	assign s_tready  = ~q_full;
	assign accept    = s_tvalid & s_tready;
	// h*101 + sign-extended char, mod 2^32
	assign next_hash = hash_q * HASH_MULT + hash_t'(signed'(s_tdata));

	// empty flag wins: char is dropped, current hash goes out
	assign push      = accept & (s_tuser | s_tlast);
	assign push_hash = s_tuser ? hash_q : next_hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			if (s_tuser || s_tlast) begin
				hash_q <= '0;
			end else begin
				hash_q <= next_hash;
			end
		end
	end

endmodule

// File: src/psh_queue.sv
`timescale 1ns / 1ps

module psh_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psh_pkg::hash_t   push_hash,
	output logic             full,
	input  logic             pop,
	output psh_pkg::q_head_t head
);
	import psh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hash_t           mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign head.avail = (count_q != '0);
	assign head.hash = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & head.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/psh_back.sv
`timescale 1ns / 1ps

module psh_back (
	input  logic             clk,
	input  logic             arst_n,
	input  psh_pkg::hash_t   slot_count,
	input  psh_pkg::q_head_t head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output psh_pkg::hash_t   m_tdata
);
	import psh_pkg::*;

	localparam int CNT_W = $clog2(HASH_W);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t             state_q;
	hash_t              dvd_q;
	hash_t              rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	hash_t              out_data_q;
	logic [HASH_W:0]    trial;
	logic [HASH_W:0]    diff;
	hash_t              rem_next;
	logic               out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = ~out_valid_q | m_tready;

	// one restoring step per cycle
	assign trial    = {rem_q, dvd_q[HASH_W-1]};
	assign diff     = trial - {1'b0, slot_count};
	assign rem_next = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];

	assign pop = (state_q == ST_IDLE) && head.avail;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dvd_q <= head.hash;
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
				rem_q <= rem_next;
			end
			default: begin
				dvd_q <= dvd_q;
				rem_q <= rem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.avail) begin
						cnt_q <= CNT_W'(HASH_W - 1);
						// zero size: no reduction, skip the divider
						state_q <= (slot_count == '0) ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			out_data_q <= (slot_count == '0) ? dvd_q : rem_q;
		end
	end

endmodule

// File: src/polynomial_string_hash.sv
`timescale 1ns / 1ps

// Polynomial string hash, base 101. Characters stream in one per item on the
// s_ side; each is sign-extended from 8 bits and folded in as
// hash = hash*101 + c (mod 2^32). The item with tlast, or with the empty flag
// in tuser, ends the string: the hash goes to a small queue and the
// accumulator clears, so the next string can stream in at one item per
// cycle; s_tready drops only when QUEUE_DEPTH finished strings wait for the
// divider. A back end takes each finished hash from the queue and reduces it
// modulo the slot count with a one-bit-per-cycle restoring divider: pop, 32
// restoring steps, output load. When the slot count is zero the divider is
// skipped and the full 32-bit hash is returned. An empty-flag item ignores
// its character and ends the string with the hash as it stands (0 after a
// clean boundary). The slot count resets to 1; the user must see that it is
// written on the cfg channel while idle, which the block does not enforce.

module polynomial_string_hash #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: slot count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // last_char
	input  logic        s_tuser,   // [0] empty_string
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] slot_index
);
	import psh_pkg::*;

	hash_t   slot_count_q;
	logic    push;
	hash_t   push_hash;
	logic    q_full;
	logic    pop;
	q_head_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= hash_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	// front: accumulate characters, push finished hashes
	psh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_hash (push_hash)
	);

	psh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_hash (push_hash),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// back: modulo reduction and output register
	psh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
